### sv/unbiased_range_reducer_unit_assert.svh
// Assertion macros for the unbiased range reducer unit
`ifndef UNBIASED_RANGE_REDUCER_UNIT_ASSERT_SVH
`define UNBIASED_RANGE_REDUCER_UNIT_ASSERT_SVH
// Clocked assertion, switched off while reset is high
`define URR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Clocked assertion that also holds through reset
`define URR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

### sv/urr_pkg.sv
// Package of types and constants shared by the range reducer files
package urr_pkg;
   localparam int MAX_WORD_BITS = 64;
   localparam int DEF_WORD_BITS = 64;
   localparam int VALUE_BITS    = 31;
   localparam int Q2_STEPS      = 31;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RETRY     = 2'd1,
      ST_NEG_LOWER = 2'd2,
      ST_ORDER     = 2'd3
   } status_type;

   typedef struct packed {
      status_type                 status;
      logic                       eq;
      logic                       reject;
      logic [VALUE_BITS-1:0]      lower;
      logic [31:0]                span;
      logic [MAX_WORD_BITS-1:0]   word;
      logic [MAX_WORD_BITS-1:0]   buckets;
      logic [MAX_WORD_BITS:0]     rem;
      logic [MAX_WORD_BITS-1:0]   quot;
   } item_type;
endpackage

### sv/urr_decode.sv
// Bounds decode stage: classify the bounds and form the span
module urr_decode import urr_pkg::*; #(
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [31:0] lower_bound,
   input  logic [31:0] upper_bound,
   input  logic [63:0] random_word,
   output logic        out_valid,
   output item_type    out_item
);
   localparam logic [MAX_WORD_BITS-1:0] WMAX = {MAX_WORD_BITS{1'b1}} >> (MAX_WORD_BITS - WORD_BITS);

   logic        valid_ff;
   item_type    item_ff, item_in;
   logic        mirror, order;
   logic [31:0] hi_neg, hi_eff;
   logic [32:0] span_w;

   always_comb begin
      mirror = (lower_bound == 32'd0) && upper_bound[31];
      hi_neg = (upper_bound == 32'h8000_0000) ? 32'h7FFF_FFFF : (~upper_bound + 32'd1);
      hi_eff = mirror ? hi_neg : upper_bound;
      order  = $signed(lower_bound) > $signed(hi_eff);
      span_w = {1'b0, hi_eff} - {1'b0, lower_bound} + 33'd1;
      item_in         = '0;
      item_in.lower   = lower_bound[VALUE_BITS-1:0];
      item_in.span    = span_w[31:0];
      item_in.word    = random_word & WMAX;
      item_in.status  = ST_OK;
      if (lower_bound[31]) begin
         item_in.status = ST_NEG_LOWER;
      end else if (lower_bound == upper_bound) begin
         item_in.eq = 1'b1;
      end else if (order) begin
         item_in.status = ST_ORDER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

### sv/urr_div_step.sv
// One registered restoring-division step
module urr_div_step import urr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  item_type                 in_item,
   input  logic [MAX_WORD_BITS-1:0] divisor,
   input  logic                     bit_in,
   output logic                     out_valid,
   output item_type                 out_item
);
   logic                   valid_ff;
   item_type               item_ff, item_in;
   logic [MAX_WORD_BITS:0] trial, diff;
   logic                   take;

   always_comb begin
      trial = {in_item.rem[MAX_WORD_BITS-1:0], bit_in};
      diff  = trial - {1'b0, divisor};
      take  = trial >= {1'b0, divisor};
      item_in      = in_item;
      item_in.rem  = take ? diff : trial;
      item_in.quot = {in_item.quot[MAX_WORD_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

### sv/unbiased_range_reducer_unit.sv
// Unbiased range reducer: maps a uniform random word onto [lower, upper] by rejection.
// One item enters per cycle while the output is not stalled, and passes through a decode
// stage, WORD_BITS restoring steps that divide the all-ones word by the span, a stage that
// checks the word against the bucket limit, 31 steps that divide the word by the bucket
// count, and the output register. A retry status asks for a fresh word with the same
// bounds. When the output is not taken the whole pipeline holds, so req_tready follows
// rsp_tready while a result waits.
module unbiased_range_reducer_unit import urr_pkg::*; #(
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // lower_bound[31:0], upper_bound[63:32], random_word[127:64]
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], value[32:2], zero fill[39:33]
   output logic [39:0]  rsp_tdata
);
   localparam logic [MAX_WORD_BITS-1:0] WMAX = {MAX_WORD_BITS{1'b1}} >> (MAX_WORD_BITS - WORD_BITS);

   logic     adv;
   logic     v1 [0:WORD_BITS];
   item_type d1 [0:WORD_BITS];
   logic     v2 [0:Q2_STEPS];
   item_type d2 [0:Q2_STEPS];
   logic     tr_valid_ff;
   item_type tr_ff, tr_in;
   logic     out_valid_ff;
   logic [1:0]            out_status_ff, out_status_in;
   logic [VALUE_BITS-1:0] out_value_ff, out_value_in;
   logic [MAX_WORD_BITS-1:0] limit;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   urr_decode #(.WORD_BITS(WORD_BITS)) u_decode (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_tvalid),
      .lower_bound(req_tdata[31:0]), .upper_bound(req_tdata[63:32]),
      .random_word(req_tdata[127:64]), .out_valid(v1[0]), .out_item(d1[0])
   );

   // bucket count = WMAX / span
   for (genvar i = 0; i < WORD_BITS; i++) begin : g_div1
      urr_div_step u_step (
         .clock(clock), .reset(reset), .adv(adv), .in_valid(v1[i]), .in_item(d1[i]),
         .divisor({{(MAX_WORD_BITS-32){1'b0}}, d1[i].span}), .bit_in(1'b1),
         .out_valid(v1[i+1]), .out_item(d1[i+1])
      );
   end

   // reject a word at or above span * buckets, which is WMAX minus the remainder
   always_comb begin
      limit          = WMAX - d1[WORD_BITS].rem[MAX_WORD_BITS-1:0];
      tr_in          = d1[WORD_BITS];
      tr_in.buckets  = d1[WORD_BITS].quot;
      tr_in.reject   = d1[WORD_BITS].word >= limit;
      tr_in.rem      = {1'b0, d1[WORD_BITS].word >> Q2_STEPS};
      tr_in.quot     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tr_valid_ff <= 1'b0;
      end else if (adv) begin
         tr_valid_ff <= v1[WORD_BITS];
      end
      if (adv) begin
         tr_ff <= tr_in;
      end
   end

   assign v2[0] = tr_valid_ff;
   assign d2[0] = tr_ff;

   // bucket index = word / buckets, known to fit 31 bits for an accepted word
   for (genvar j = 0; j < Q2_STEPS; j++) begin : g_div2
      urr_div_step u_step (
         .clock(clock), .reset(reset), .adv(adv), .in_valid(v2[j]), .in_item(d2[j]),
         .divisor(d2[j].buckets), .bit_in(d2[j].word[Q2_STEPS-1-j]),
         .out_valid(v2[j+1]), .out_item(d2[j+1])
      );
   end

   always_comb begin
      out_status_in = d2[Q2_STEPS].status;
      out_value_in  = '0;
      if (d2[Q2_STEPS].status == ST_OK) begin
         if (d2[Q2_STEPS].eq) begin
            out_value_in = d2[Q2_STEPS].lower;
         end else if (d2[Q2_STEPS].reject) begin
            out_status_in = ST_RETRY;
         end else begin
            out_value_in = d2[Q2_STEPS].quot[VALUE_BITS-1:0] + d2[Q2_STEPS].lower;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= v2[Q2_STEPS];
      end
      if (adv) begin
         out_status_ff <= out_status_in;
         out_value_ff  <= out_value_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_value_ff, out_status_ff};
endmodule

### sv/urr_checker.sv
// Port checker for the range reducer, bound to the top level
`include "unbiased_range_reducer_unit_assert.svh"
module urr_checker import urr_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [127:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata
);
   `URR_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "stalled result item changed")
   `URR_ASSERT(a_value_zero, (rsp_tvalid && (rsp_tdata[1:0] != ST_OK)) |-> (rsp_tdata[32:2] == 31'd0), "value not zero for a failing status")
   `URR_ASSERT(a_ready, req_tready == (!rsp_tvalid || rsp_tready), "input ready does not follow output stall")
   `URR_ASSERT(a_fill, rsp_tdata[39:33] == 7'd0, "fill bits of result not zero")
endmodule

bind unbiased_range_reducer_unit urr_checker u_urr_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

### tb/tb_unbiased_range_reducer_unit.sv
// Self-checking testbench for the unbiased range reducer unit
`timescale 1ns / 1ps

module tb_unbiased_range_reducer_unit;
   import urr_pkg::*;

   localparam logic [63:0] WORD_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          PIPE_DEPTH    = DEF_WORD_BITS + 34;
   localparam int          STALL_LIMIT   = 20000;

   typedef struct {
      status_type  status;
      logic [30:0] value;
   } draw_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;

   draw_result_type pending_draws[$];
   int           mismatch_count;
   int           sender_idle_pct;
   int           receiver_idle_pct;
   bit           hold_receiver;
   int           quiet_cycles;

   unbiased_range_reducer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Map one word onto the requested range by rejection
   function automatic draw_result_type reduce_draw(logic [31:0] lo_bits, logic [31:0] hi_bits,
                                                   logic [63:0] word);
      draw_result_type r;
      longint       lo;
      longint       hi;
      logic [63:0]  span;
      logic [63:0]  buckets;
      logic [63:0]  limit;
      logic [63:0]  quot;
      lo = longint'($signed(lo_bits));
      hi = longint'($signed(hi_bits));
      r.status = ST_OK;
      r.value  = '0;
      if (lo < 0) begin
         r.status = ST_NEG_LOWER;
         return r;
      end
      if (lo == hi) begin
         r.value = hi_bits[30:0];
         return r;
      end
      if (lo == 0 && hi < 0) begin
         hi = -hi;
         if (hi > longint'(32'h7FFF_FFFF)) hi = longint'(32'h7FFF_FFFF);
      end
      if (lo > hi) begin
         r.status = ST_ORDER;
         return r;
      end
      span    = 64'(hi - lo) + 64'd1;
      buckets = WORD_ALL_ONES / span;
      limit   = span * buckets;
      if (word >= limit) begin
         r.status = ST_RETRY;
         return r;
      end
      quot    = word / buckets + 64'(lo);
      r.value = quot[30:0];
      return r;
   endfunction

   // Record each accepted request, check each accepted result, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_draws.push_back(reduce_draw(req_tdata[31:0], req_tdata[63:32],
                                                req_tdata[127:64]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_draws.size() == 0) begin
               $display("%0t: unexpected result status=%0d value=%0d", $time,
                        rsp_tdata[1:0], rsp_tdata[32:2]);
               mismatch_count++;
            end else begin
               draw_result_type want;
               want = pending_draws.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_tdata[1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[32:2] !== want.value) begin
                  $display("%0t: value expected %0d actual %0d", $time, want.value,
                           rsp_tdata[32:2]);
                  mismatch_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_receiver && ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic send_draw(logic [31:0] lo, logic [31:0] hi, logic [63:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {word, hi, lo};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic release_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_draw(32'd0, 32'd0, 64'd0);
      send_draw(32'd5, 32'd5, WORD_ALL_ONES);
      send_draw(32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'd17);
      send_draw(32'hFFFF_FFFF, 32'd10, 64'd1);
      send_draw(32'h8000_0000, 32'h7FFF_FFFF, 64'd1);
      send_draw(32'd10, 32'd3, 64'd0);
      send_draw(32'h7FFF_FFFF, 32'd0, 64'd0);
      send_draw(32'd5, 32'hFFFF_FFFB, 64'd0);
      send_draw(32'd0, 32'hFFFF_FFFF, WORD_ALL_ONES - 64'd1);
      send_draw(32'd0, 32'hFFFF_FFF6, 64'h1234_5678_9ABC_DEF0);
      // Most negative upper bound mirrors and saturates
      send_draw(32'd0, 32'h8000_0000, 64'h8000_0000_0000_0000);
      send_draw(32'd0, 32'h8000_0001, WORD_ALL_ONES);
      send_draw(32'd0, 32'h7FFF_FFFF, 64'd0);
      send_draw(32'd0, 32'h7FFF_FFFF, WORD_ALL_ONES);
      send_draw(32'd0, 32'h7FFF_FFFF, WORD_ALL_ONES - 64'h7FFF_FFFF);
      send_draw(32'd1, 32'h7FFF_FFFF, WORD_ALL_ONES - 64'h7FFF_FFFF);
      send_draw(32'd0, 32'd2, WORD_ALL_ONES);
      send_draw(32'd0, 32'd2, WORD_ALL_ONES - 64'd1);
      send_draw(32'd0, 32'd1, WORD_ALL_ONES);
      send_draw(32'd100, 32'd102, 64'hAAAA_AAAA_AAAA_AAAA);
      send_draw(32'd0, 32'd6, 64'hFFFF_FFFF_FFFF_FFFB);
      send_draw(32'h4000_0000, 32'h7FFF_FFFF, 64'h5555_5555_5555_5555);
      release_sender();
   endtask

   task automatic test_random(int count);
      repeat (count) begin
         logic [31:0] lo;
         logic [31:0] hi;
         logic [63:0] word;
         logic [63:0] span;
         int          pick;
         pick = $urandom_range(99);
         word = {$urandom, $urandom};
         lo   = $urandom_range(32'h7FFF_FFFF);
         hi   = $urandom;
         if (pick < 35) begin
            lo = $urandom_range(1000);
            hi = lo + $urandom_range(1000);
         end else if (pick < 55) begin
            lo = $urandom_range(32'h3FFF_FFFF);
            hi = lo + $urandom_range(32'h3FFF_FFFF);
         end else if (pick < 65) begin
            lo = 32'd0;
            hi = -$urandom_range(32'h7FFF_FFFF) - 1;
         end else if (pick < 70) begin
            hi = lo;
         end else if (pick < 75) begin
            lo = $urandom | 32'h8000_0000;
         end
         // Aim a share of words at the rejection boundary
         if (pick >= 20 && pick < 85 && $urandom_range(2) == 0) begin
            longint l;
            longint h;
            l = longint'($signed(lo));
            h = longint'($signed(hi));
            if (l == 0 && h < 0) h = (h == -longint'(32'h8000_0000)) ?
                                      longint'(32'h7FFF_FFFF) : -h;
            if (l >= 0 && h > l) begin
               span = 64'(h - l) + 64'd1;
               word = span * (WORD_ALL_ONES / span) - 64'd2 + 64'($urandom_range(3));
            end
         end
         send_draw(lo, hi, word);
      end
      release_sender();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_receiver = 1'b1;
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end
         test_random(150);
      join
   endtask

   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      rsp_tready        = 1'b0;
      mismatch_count    = 0;
      quiet_cycles      = 0;
      hold_receiver     = 1'b0;
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      sender_idle_pct   = 22;
      receiver_idle_pct = 50;
      test_random(250);
      sender_idle_pct   = 50;
      receiver_idle_pct = 22;
      test_random(250);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random(250);
      test_backpressure();

      while (pending_draws.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (mismatch_count == 0 && pending_draws.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
